### src/oaht_pkg.sv
package oaht_pkg;

   localparam int SIZE_W     = 11;
   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 32;
   localparam int DIGITS     = 10;
   localparam int SIZE_MIN   = 10;
   localparam int SIZE_RESET = 100;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [KEY_W-1:0]   key;
      logic [VALUE_W-1:0]        value;
   } req_type;

   typedef struct packed {
      logic                      success;
      logic [VALUE_W-1:0]        found_value;
   } rsp_type;

   // start/finish handshake between the sequencer and a worker unit
   typedef struct packed {
      logic start;
   } unit_cmd_type;

   typedef struct packed {
      logic done;
   } unit_sts_type;

endpackage

### src/oaht_ram.sv
module oaht_ram #(
   parameter int WIDTH = 65,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/oaht_mod.sv
module oaht_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  oaht_pkg::unit_cmd_type      cmd,
   input  logic [31:0]                 dividend,
   input  logic [oaht_pkg::SIZE_W-1:0] divisor,
   output oaht_pkg::unit_sts_type      sts,
   output logic [oaht_pkg::SIZE_W-1:0] remainder
);
   import oaht_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [31:0]       num_ff, num_in;
   logic [SIZE_W-1:0] div_ff, div_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W:0]   trial;

   // one restoring remainder step per cycle, most significant bit first
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[31]};
      if (cmd.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[30:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = SIZE_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = SIZE_W'(trial);
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign sts.done  = done_ff;
   assign remainder = rem_ff;

endmodule

### src/oaht_fold.sv
module oaht_fold (
   input  logic                        clock,
   input  logic                        reset,
   input  oaht_pkg::unit_cmd_type      cmd,
   input  logic [31:0]                 mag,
   input  logic [oaht_pkg::SIZE_W-1:0] size,
   output oaht_pkg::unit_sts_type      sts,
   output logic [oaht_pkg::SIZE_W-1:0] home
);
   import oaht_pkg::*;

   typedef enum logic [4:0] {
      F_IDLE  = 5'b00001,
      F_CONV  = 5'b00010,
      F_TOP   = 5'b00100,
      F_FOLD  = 5'b01000,
      F_CHECK = 5'b10000
   } fold_state_type;

   fold_state_type    state_ff, state_in;
   logic              done_ff, done_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [31:0]       shr_ff, shr_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] home_ff, home_in;
   logic [3:0]        top_ff, top_in;
   logic [3:0]        dig_ff [DIGITS];
   logic [3:0]        dig_in [DIGITS];
   logic [3:0]        adj    [DIGITS];
   logic [4:0]        psum;
   logic [16:0]       fval;

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      cnt_in   = cnt_ff;
      shr_in   = shr_ff;
      size_in  = size_ff;
      home_in  = home_ff;
      top_in   = top_ff;
      dig_in   = dig_ff;
      psum     = '0;
      for (int k = 0; k < DIGITS; k++) begin
         adj[k] = (dig_ff[k] >= 4'd5) ? dig_ff[k] + 4'd3 : dig_ff[k];
      end
      fval = 17'(dig_ff[0]) + 17'(dig_ff[1]) * 17'd10 + 17'(dig_ff[2]) * 17'd100
           + 17'(dig_ff[3]) * 17'd1000 + 17'(dig_ff[4]) * 17'd10000;
      case (state_ff)
         F_IDLE: begin
            if (cmd.start) begin
               done_in = 1'b0;
               size_in = size;
               shr_in  = mag;
               cnt_in  = '0;
               for (int k = 0; k < DIGITS; k++) begin
                  dig_in[k] = '0;
               end
               // small magnitudes are their own home slot
               if (mag <= 32'(size)) begin
                  home_in = SIZE_W'(mag);
                  done_in = 1'b1;
               end else begin
                  state_in = F_CONV;
               end
            end
         end
         F_CONV: begin
            // binary to decimal, one bit per cycle
            dig_in[0] = {adj[0][2:0], shr_ff[31]};
            for (int k = 1; k < DIGITS; k++) begin
               dig_in[k] = {adj[k][2:0], adj[k-1][3]};
            end
            shr_in = {shr_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = F_TOP;
            end
         end
         F_TOP: begin
            // find the highest non-zero digit
            top_in = '0;
            for (int k = 0; k < DIGITS; k++) begin
               if (dig_ff[k] != 4'd0) begin
                  top_in = 4'(k);
               end
            end
            state_in = F_FOLD;
         end
         F_FOLD: begin
            // add the outermost pairs modulo ten, drop the upper half
            for (int k = 0; k < DIGITS; k++) begin
               for (int j = 0; j < DIGITS; j++) begin
                  if (k < j && 4'(j + k) == top_ff) begin
                     psum = 5'(dig_ff[k]) + 5'(dig_ff[j]);
                     dig_in[k] = (psum >= 5'd10) ? 4'(psum - 5'd10) : 4'(psum);
                     dig_in[j] = '0;
                  end
               end
            end
            top_in   = top_ff >> 1;
            state_in = F_CHECK;
         end
         F_CHECK: begin
            if (fval > 17'(size_ff)) begin
               state_in = F_FOLD;
            end else begin
               home_in  = SIZE_W'(fval);
               done_in  = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      shr_ff  <= shr_in;
      size_ff <= size_in;
      home_ff <= home_in;
      top_ff  <= top_in;
      dig_ff  <= dig_in;
   end

   assign sts.done = done_ff;
   assign home     = home_ff;

endmodule

### src/open_address_hash_table_double_hash_core.sv
// Channel  Direction  Ports                         Transfer
// req      in         req_valid/req_ready/req_data  valid & ready
// rsp      out        rsp_valid/rsp_ready/rsp_data  valid & ready
// csr      in         csr_we/csr_wdata              csr_we, no wait
//
// After reset a clearing pass writes every one of the MAX_SLOTS slots empty;
// no item is accepted meanwhile.
// One item at a time: hashing (the 32-step remainder unit and the digit fold
// unit run side by side, each fold passing through a fold and a check state),
// then a probe state and a check state per probe through the slot memory read
// port, up to size probes. Unknown ops skip hashing; inserts into a full table
// skip probing. A waiting result holds the next result back, not the next item.
module open_address_hash_table_double_hash_core #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  oaht_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output oaht_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [oaht_pkg::SIZE_W-1:0]    csr_wdata
);
   import oaht_pkg::*;

   localparam int AW       = $clog2(MAX_SLOTS);
   localparam int CW       = $clog2(MAX_SLOTS + 1);
   localparam int SIZE_CAP = (MAX_SLOTS < 2047) ? MAX_SLOTS : 2047;
   localparam int WORD_W   = 1 + KEY_W + VALUE_W;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_HASH  = 6'b000100,
      S_PROBE = 6'b001000,
      S_CHECK = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  csr_size_ff;
   logic [SIZE_W-1:0]  eff_size;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [1:0]         op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [31:0]        mag_ff, mag_in;
   logic [SIZE_W-1:0]  step_ff, step_in;
   logic [SIZE_W-1:0]  pos_ff, pos_in;
   logic [SIZE_W-1:0]  inc_ff, inc_in;
   logic [SIZE_W-1:0]  idx_ff, idx_in;
   logic               ok_ff, ok_in;
   logic [VALUE_W-1:0] fv_ff, fv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [SIZE_W:0]    pos_sum, inc_sum;
   logic               full;

   unit_cmd_type       unit_cmd;
   unit_sts_type       mod_sts, fold_sts;
   logic [SIZE_W-1:0]  rem;
   logic [SIZE_W-1:0]  home;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [WORD_W-1:0]  ram_wdata, ram_rdata;
   logic               slot_valid;
   logic [KEY_W-1:0]   slot_key;
   logic [VALUE_W-1:0] slot_value;

   // saturate the configured size to the supported range
   always_comb begin
      eff_size = (csr_size_ff < SIZE_W'(SIZE_MIN)) ? SIZE_W'(SIZE_MIN) : csr_size_ff;
      if (32'(eff_size) > SIZE_CAP) begin
         eff_size = SIZE_W'(SIZE_CAP);
      end
   end

   assign full = (32'(count_ff) >= 32'(size_ff));
   assign {slot_valid, slot_key, slot_value} = ram_rdata;

   oaht_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .cmd       (unit_cmd),
      .dividend  (mag_ff),
      .divisor   (size_ff - SIZE_W'(1)),
      .sts       (mod_sts),
      .remainder (rem)
   );

   oaht_fold u_fold (
      .clock (clock),
      .reset (reset),
      .cmd   (unit_cmd),
      .mag   (mag_ff),
      .size  (size_ff),
      .sts   (fold_sts),
      .home  (home)
   );

   oaht_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      mag_in       = mag_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      inc_in       = inc_ff;
      idx_in       = idx_ff;
      ok_in        = ok_ff;
      fv_in        = fv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      unit_cmd     = '0;
      ram_we       = 1'b0;
      ram_waddr    = AW'(pos_ff);
      ram_wdata    = {1'b1, key_ff, val_ff};
      ram_raddr    = AW'(pos_ff);
      pos_sum      = {1'b0, pos_ff} + {1'b0, inc_ff};
      inc_sum      = {1'b0, inc_ff} + {1'b0, step_ff};
      req_ready    = (state_ff == S_IDLE);

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.op;
               key_in  = req_data.key;
               val_in  = req_data.value;
               mag_in  = req_data.key[KEY_W-1] ? 32'(0) - req_data.key : req_data.key;
               size_in = eff_size;
               ok_in   = 1'b0;
               fv_in   = '0;
               if (req_data.op == OP_INSERT || req_data.op == OP_SEARCH ||
                   req_data.op == OP_REMOVE) begin
                  state_in = S_HASH;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_HASH: begin
            // start both hash units, then wait for both
            if (idx_ff != '1) begin
               unit_cmd.start = 1'b1;
               idx_in         = '1;
            end else if (mod_sts.done && fold_sts.done && !unit_cmd.start) begin
               step_in = rem + SIZE_W'(1);
               pos_in  = home;
               inc_in  = '0;
               idx_in  = '0;
               if (op_ff == OP_INSERT && full) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            // advance to the next slot and read it
            pos_in    = (pos_sum >= {1'b0, size_ff}) ? SIZE_W'(pos_sum - {1'b0, size_ff})
                                                    : SIZE_W'(pos_sum);
            inc_in    = (inc_sum >= {1'b0, size_ff}) ? SIZE_W'(inc_sum - {1'b0, size_ff})
                                                    : SIZE_W'(inc_sum);
            ram_raddr = AW'(pos_in);
            idx_in    = idx_ff + SIZE_W'(1);
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (op_ff == OP_INSERT) begin
               if (!slot_valid) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CW'(1);
                  ok_in    = 1'b1;
                  state_in = S_DONE;
               end else if (idx_ff == size_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_PROBE;
               end
            end else begin
               if (!slot_valid) begin
                  state_in = S_DONE;
               end else if (slot_key == key_ff) begin
                  ok_in = 1'b1;
                  fv_in = slot_value;
                  if (op_ff == OP_REMOVE) begin
                     ram_we    = 1'b1;
                     ram_wdata = '0;
                     if (count_ff != '0) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  state_in = S_DONE;
               end else if (idx_ff == size_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_DONE: begin
            // hand over the result once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.success     = ok_ff;
               rsp_in.found_value = fv_ff;
               idx_in             = '0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         csr_size_ff  <= SIZE_W'(SIZE_RESET);
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         if (csr_we) begin
            csr_size_ff <= csr_wdata;
         end
      end
      size_ff <= size_in;
      op_ff   <= op_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      mag_ff  <= mag_in;
      step_ff <= step_in;
      pos_ff  <= pos_in;
      inc_ff  <= inc_in;
      ok_ff   <= ok_in;
      fv_ff   <= fv_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
